>>> rtl/core/hstg_pkg.sv
// Shared types and constants of the harmony sine tone generator.
`default_nettype none

package hstg_pkg;

    typedef logic [2:0] t_reg_idx;
    typedef logic [2:0] t_role;

    localparam t_reg_idx REG_VOLUME      = 3'd0;
    localparam t_reg_idx REG_HARMONY_EN  = 3'd1;
    localparam t_reg_idx REG_ROLE        = 3'd2;
    localparam t_reg_idx REG_RATIO_DOWN  = 3'd3;
    localparam t_reg_idx REG_RATIO_UP    = 3'd4;
    localparam t_reg_idx REG_RATIO_FIFTH = 3'd5;
    localparam t_reg_idx REG_MIN_FREQ    = 3'd6;

    localparam t_role ROLE_DOWN  = 3'd2;
    localparam t_role ROLE_UP    = 3'd3;
    localparam t_role ROLE_FIFTH = 3'd4;

    localparam logic [15:0] VOLUME_RST      = 16'd32768;
    localparam t_role       ROLE_RST        = 3'd1;
    localparam logic [15:0] RATIO_DOWN_RST  = 16'd2048;
    localparam logic [15:0] RATIO_UP_RST    = 16'd8192;
    localparam logic [15:0] RATIO_FIFTH_RST = 16'd6144;
    localparam logic [15:0] MIN_FREQ_RST    = 16'd50;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [8:0]  TAYLOR_DIV [0:7] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                                 9'd110, 9'd156, 9'd210, 9'd272};

endpackage

`default_nettype wire

>>> rtl/core/harmony_sine_tone_generator_unit.sv
// Top level of the harmony sine tone generator: config port, sequencer and shared multiplier.
//
// Input channel: i_in_valid / o_in_stall carry one request (i_tone_freq, hertz).
// Output channel: o_out_valid / i_out_stall carry one sample (o_sample, signed).
// A transaction moves on a rising edge with valid high and stall low.
// Each request yields exactly one sample.
// One shared 16 x MB multiplier does the harmony scaling, the table index, the
// integer part of the phase step, the volume scaling and the fractional part of
// the phase step in turn, with a registered quarter-wave table read, under a
// small sequencer. A tone runs through XF, XFR, ROM, VOL, STR, ADV and DONE
// before o_out_valid; a rest (zero frequency after the harmony transform) goes
// from XFR to DONE and leaves the phase untouched. The five multiplier passes
// and the phase add run one after another; o_in_stall is high while a request
// is in work. The finished sample sits in an output register, so a new request
// is taken while it waits; a stalled sample holds and the next one waits in the
// sequencer until the register frees. Reset (synchronous, i_rst_n low) clears
// the phase, the sequencer state and the output valid and restores the register
// defaults. The APB port writes registers at byte address 4*i.
`default_nettype none

module harmony_sine_tone_generator_unit #(
    parameter int SAMPLE_RATE_HZ   = 16000,
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [15:0]        i_tone_freq,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_sample,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int QB    = PHASE_BITS - 2;
    localparam logic [63:0] STEP_Q = (64'd1 << PHASE_BITS) / 64'(SAMPLE_RATE_HZ);
    localparam logic [63:0] STEP_R = (64'd1 << PHASE_BITS) % 64'(SAMPLE_RATE_HZ);
    localparam int QW    = $clog2(STEP_Q + 64'd1);
    localparam int SRW   = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int RK    = 16 + SRW;
    localparam logic [63:0] STEP_M = ((STEP_R << RK) + 64'(SAMPLE_RATE_HZ) - 64'd1)
                                     / 64'(SAMPLE_RATE_HZ);
    localparam int MB_A  = (QB > QW) ? QB : QW;
    localparam int MB_B  = (MB_A > RK) ? MB_A : RK;
    localparam int MB    = (MB_B > 16) ? MB_B : 16;
    localparam int PW    = 16 + MB;
    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XF   = 4'd1;
    localparam logic [3:0] S_XFR  = 4'd2;
    localparam logic [3:0] S_ROM  = 4'd3;
    localparam logic [3:0] S_VOL  = 4'd4;
    localparam logic [3:0] S_STR  = 4'd5;
    localparam logic [3:0] S_ADV  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    function automatic logic [14:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] ent;
        int n;
        x    = (64'(k) * hstg_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'(hstg_pkg::TAYLOR_DIV[n-1]);
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        ent = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (ent > 64'd32767) begin
            ent = 64'd32767;
        end
        return ent[14:0];
    endfunction

    logic [14:0] w_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [14:0] ENTRY = sine_entry(k);
        assign w_rom[k] = ENTRY;
    end

    logic [15:0]       r_volume;
    logic              r_harmony;
    hstg_pkg::t_role   r_role;
    logic [15:0]       r_ratio_down;
    logic [15:0]       r_ratio_up;
    logic [15:0]       r_ratio_fifth;
    logic [15:0]       r_min_freq;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [15:0]       r_freq;
    logic [15:0]       r_f;
    logic [PW-1:0]     r_prod;
    logic [14:0]       r_rom;
    logic signed [15:0] r_sample;
    logic              r_out_valid;
    logic signed [15:0] r_sample_out;

    logic [15:0]       w_mul_a;
    logic [MB-1:0]     w_mul_b;
    logic [PW-1:0]     w_prod;
    logic [15:0]       w_ratio;
    logic [15:0]       w_sat;
    logic              w_role_xf;
    logic [15:0]       w_f;
    logic [IW-1:0]     w_idx;
    logic [IW-1:0]     w_rd_idx;
    logic [14:0]       w_mag;
    logic [1:0]        w_quad;
    logic              w_out_free;
    logic              w_wr;
    hstg_pkg::t_reg_idx w_reg;

    assign pready      = 1'b1;
    assign w_reg       = paddr[4:2];
    assign w_wr        = psel && penable && pwrite;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (w_reg)
            hstg_pkg::REG_VOLUME:      prdata = 32'(r_volume);
            hstg_pkg::REG_HARMONY_EN:  prdata = 32'(r_harmony);
            hstg_pkg::REG_ROLE:        prdata = 32'(r_role);
            hstg_pkg::REG_RATIO_DOWN:  prdata = 32'(r_ratio_down);
            hstg_pkg::REG_RATIO_UP:    prdata = 32'(r_ratio_up);
            hstg_pkg::REG_RATIO_FIFTH: prdata = 32'(r_ratio_fifth);
            hstg_pkg::REG_MIN_FREQ:    prdata = 32'(r_min_freq);
            default:                   prdata = 32'd0;
        endcase
    end

    always_comb begin
        case (r_role)
            hstg_pkg::ROLE_DOWN:  w_ratio = r_ratio_down;
            hstg_pkg::ROLE_FIFTH: w_ratio = r_ratio_fifth;
            default:              w_ratio = r_ratio_up;
        endcase
    end

    assign w_quad    = r_phase[PHASE_BITS-1 -: 2];
    assign w_sat     = (|r_prod[31:28]) ? 16'hFFFF : r_prod[27:12];
    assign w_role_xf = (r_role == hstg_pkg::ROLE_DOWN) || (r_role == hstg_pkg::ROLE_UP)
                    || (r_role == hstg_pkg::ROLE_FIFTH);

    always_comb begin
        if (!r_harmony || r_freq == 16'd0 || !w_role_xf) begin
            w_f = r_freq;
        end else if (r_role == hstg_pkg::ROLE_DOWN && w_sat < r_min_freq) begin
            w_f = r_freq;
        end else begin
            w_f = w_sat;
        end
    end

    assign w_idx    = r_prod[QB +: IW];
    assign w_rd_idx = w_quad[0] ? (IW'(SINE_TABLE_DEPTH) - w_idx) : w_idx;
    assign w_mag    = r_prod[30:16];

    always_comb begin
        unique case (r_state)
            S_XF: begin
                w_mul_a = r_freq;
                w_mul_b = MB'(w_ratio);
            end
            S_XFR: begin
                w_mul_a = 16'(SINE_TABLE_DEPTH);
                w_mul_b = MB'(r_phase[QB-1:0]);
            end
            S_ROM: begin
                w_mul_a = r_f;
                w_mul_b = MB'(STEP_Q);
            end
            S_VOL: begin
                w_mul_a = r_volume;
                w_mul_b = MB'(r_rom);
            end
            S_STR: begin
                w_mul_a = r_f;
                w_mul_b = MB'(STEP_M);
            end
            default: begin
                w_mul_a = 16'd0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_XF;
            S_XF:   n_state = S_XFR;
            S_XFR:  n_state = (w_f == 16'd0) ? S_DONE : S_ROM;
            S_ROM:  n_state = S_VOL;
            S_VOL:  n_state = S_STR;
            S_STR:  n_state = S_ADV;
            S_ADV:  n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_state == S_IDLE) begin
            r_freq <= i_tone_freq;
        end
        if (r_state == S_XFR) begin
            r_f <= w_f;
            if (w_f == 16'd0) begin
                r_sample <= 16'sd0;
            end
        end
        if (r_state == S_ROM) begin
            r_rom <= w_rom[w_rd_idx];
        end
        if (r_state == S_VOL) begin
            r_step <= r_prod[PHASE_BITS-1:0];
        end
        if (r_state == S_STR) begin
            r_sample <= w_quad[1] ? signed'(16'd0 - {1'b0, w_mag}) : signed'({1'b0, w_mag});
        end
        if (r_state == S_DONE && w_out_free) begin
            r_sample_out <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
            r_volume      <= hstg_pkg::VOLUME_RST;
            r_harmony     <= 1'b0;
            r_role        <= hstg_pkg::ROLE_RST;
            r_ratio_down  <= hstg_pkg::RATIO_DOWN_RST;
            r_ratio_up    <= hstg_pkg::RATIO_UP_RST;
            r_ratio_fifth <= hstg_pkg::RATIO_FIFTH_RST;
            r_min_freq    <= hstg_pkg::MIN_FREQ_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_ADV) begin
                r_phase <= r_phase + r_step + PHASE_BITS'(r_prod[RK +: 16]);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr) begin
                unique case (w_reg)
                    hstg_pkg::REG_VOLUME:      r_volume      <= pwdata[15:0];
                    hstg_pkg::REG_HARMONY_EN:  r_harmony     <= pwdata[0];
                    hstg_pkg::REG_ROLE:        r_role        <= pwdata[2:0];
                    hstg_pkg::REG_RATIO_DOWN:  r_ratio_down  <= pwdata[15:0];
                    hstg_pkg::REG_RATIO_UP:    r_ratio_up    <= pwdata[15:0];
                    hstg_pkg::REG_RATIO_FIFTH: r_ratio_fifth <= pwdata[15:0];
                    hstg_pkg::REG_MIN_FREQ:    r_min_freq    <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_XF))
        else $error("accepted transaction did not start the sequencer");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ADV) |=> $stable(r_phase))
        else $error("phase moved outside the advance step");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != 16'sh8000))
        else $error("sample out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output transaction not loaded from the done state");

endmodule

`default_nettype wire

>>> tb/sv/sine_sample_checker.sv
// Checker for the harmony sine tone generator: predicts each sample and compares it.
`timescale 1ns / 1ps

module sine_sample_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_tone_freq,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_sample,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_mismatches,
    output int                 o_pending
);

    localparam logic [15:0]     VOLUME_AT_RESET      = 16'd32768;
    localparam hstg_pkg::t_role PART_AT_RESET        = 3'd1;
    localparam logic [15:0]     RATIO_DOWN_AT_RESET  = 16'd2048;
    localparam logic [15:0]     RATIO_UP_AT_RESET    = 16'd8192;
    localparam logic [15:0]     RATIO_FIFTH_AT_RESET = 16'd6144;
    localparam logic [15:0]     MIN_FREQ_AT_RESET    = 16'd50;
    localparam logic [63:0]     TONE_RATE_HZ         = 64'd16000;
    localparam logic [10:0]     TABLE_DEPTH          = 11'd1024;
    localparam logic [63:0]     HALF_PI_FIXED        = 64'd1686629713;

    logic [15:0]        sine_quarter [0:1024];
    logic [15:0]        volume;
    logic               harmony_on;
    hstg_pkg::t_role    part;
    logic [15:0]        ratio_down;
    logic [15:0]        ratio_up;
    logic [15:0]        ratio_fifth;
    logic [15:0]        min_freq;
    logic [31:0]        phase_acc;
    logic signed [15:0] samples_due [$];
    int                 mismatches;

    initial begin : build_sine
        logic [63:0] x, x2, term, sum, ent, div;
        for (int k = 0; k <= 1024; k++) begin
            x = 64'(k);
            x = (x * HALF_PI_FIXED) / 64'd1024;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 8; n++) begin
                div = 64'(2 * n * (2 * n + 1));
                term = ((term * x2) >> 30) / div;
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            ent = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (ent > 64'd32767) begin
                ent = 64'd32767;
            end
            sine_quarter[k] = ent[15:0];
        end
    end

    function automatic logic [15:0] scaled(input logic [15:0] tone, input logic [15:0] ratio);
        logic [31:0] prod;
        prod = 32'(tone);
        prod = (prod * 32'(ratio)) >> 12;
        return (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
    endfunction

    function automatic logic [15:0] harmonize(input logic [15:0] tone);
        logic [15:0] shifted;
        shifted = tone;
        if (tone != 16'd0 && harmony_on) begin
            case (part)
                hstg_pkg::ROLE_DOWN: begin
                    shifted = scaled(tone, ratio_down);
                    if (shifted < min_freq) begin
                        shifted = tone;
                    end
                end
                hstg_pkg::ROLE_UP:    shifted = scaled(tone, ratio_up);
                hstg_pkg::ROLE_FIFTH: shifted = scaled(tone, ratio_fifth);
                default:              shifted = tone;
            endcase
        end
        return shifted;
    endfunction

    // return the sample for one request and advance the phase unless it is a rest
    function automatic logic signed [15:0] synth_sample(input logic [15:0] tone);
        logic [15:0] freq;
        logic [1:0]  quad;
        logic [10:0] slot;
        logic [31:0] mag;
        logic [63:0] wide;
        freq = harmonize(tone);
        if (freq == 16'd0) begin
            return 16'sd0;
        end
        quad = phase_acc[31:30];
        slot = {1'b0, phase_acc[29:20]};
        if (quad[0]) begin
            slot = TABLE_DEPTH - slot;
        end
        mag = 32'(sine_quarter[slot]);
        mag = (mag * 32'(volume)) >> 16;
        wide = {16'd0, freq, 32'd0};
        wide = wide / TONE_RATE_HZ;
        phase_acc = phase_acc + wide[31:0];
        return quad[1] ? -mag[15:0] : mag[15:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [15:0] due;
        if (!i_rst_n) begin
            volume      = VOLUME_AT_RESET;
            harmony_on  = 1'b0;
            part        = PART_AT_RESET;
            ratio_down  = RATIO_DOWN_AT_RESET;
            ratio_up    = RATIO_UP_AT_RESET;
            ratio_fifth = RATIO_FIFTH_AT_RESET;
            min_freq    = MIN_FREQ_AT_RESET;
            phase_acc   = 32'd0;
            samples_due.delete();
            mismatches  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (hstg_pkg::t_reg_idx'(i_paddr[4:2]))
                    hstg_pkg::REG_VOLUME:      volume      = i_pwdata[15:0];
                    hstg_pkg::REG_HARMONY_EN:  harmony_on  = i_pwdata[0];
                    hstg_pkg::REG_ROLE:        part        = i_pwdata[2:0];
                    hstg_pkg::REG_RATIO_DOWN:  ratio_down  = i_pwdata[15:0];
                    hstg_pkg::REG_RATIO_UP:    ratio_up    = i_pwdata[15:0];
                    hstg_pkg::REG_RATIO_FIFTH: ratio_fifth = i_pwdata[15:0];
                    hstg_pkg::REG_MIN_FREQ:    min_freq    = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    $error("sample: expected none, actual %0d", i_sample);
                    mismatches++;
                end else begin
                    due = samples_due.pop_front();
                    if (i_sample !== due) begin
                        $error("sample: expected %0d, actual %0d", due, i_sample);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                samples_due.push_back(synth_sample(i_tone_freq));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= samples_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for the harmony sine tone generator: stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam hstg_pkg::t_reg_idx REG_UNUSED = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_tone_freq = 16'd0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_sample;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = 5'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    logic               calm = 1'b0;

    harmony_sine_tone_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_tone_freq (i_tone_freq),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sine_sample_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_tone_freq  (i_tone_freq),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample     (o_sample),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : take_samples
        int hold;
        int calm_left;
        calm_left = 0;
        @(posedge i_clk);
        forever begin
            if (calm_left > 0) begin
                hold = 0;
                calm_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                hold = 0;
                calm_left = $urandom_range(10, 60);
            end else begin
                hold = $urandom_range(0, 13);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send(input logic [15:0] tone);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_tone_freq <= tone;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_samples_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // write one register over APB, with noise in the bits above the register width
    task automatic write_reg(input hstg_pkg::t_reg_idx idx, input logic [15:0] value,
                             input int width);
        logic [31:0] word;
        word = $urandom();
        for (int b = 0; b < width; b++) begin
            word[b] = value[b];
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_word();
        int r;
        case ($urandom_range(0, 5))
            0:       r = 0;
            1:       r = 65535;
            2, 3:    r = $urandom_range(1024, 12288);
            default: r = $urandom_range(0, 65535);
        endcase
        return r[15:0];
    endfunction

    function automatic logic [15:0] pick_tone();
        int r;
        case ($urandom_range(0, 11))
            0:          r = 0;
            1:          r = $urandom_range(1, 63);
            2, 3, 4, 5: r = $urandom_range(20, 5000);
            6:          r = $urandom_range(1, 16) * 4000;
            7:          r = 65535 - $urandom_range(0, 15);
            default:    r = $urandom_range(0, 65535);
        endcase
        return r[15:0];
    endfunction

    task automatic configure(input int round);
        logic [15:0]     vol, r_down, r_up, r_fifth, floor_hz;
        logic            harmony;
        hstg_pkg::t_role part;
        int              r;
        if (round == 0) begin
            vol = '0; harmony = 1'b0; part = '0;
            r_down = '0; r_up = '0; r_fifth = '0; floor_hz = '0;
        end else if (round == 1) begin
            vol = '1; harmony = 1'b1; part = '1;
            r_down = '1; r_up = '1; r_fifth = '1; floor_hz = '1;
        end else begin
            vol = pick_word();
            harmony = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: part = hstg_pkg::ROLE_DOWN;
                3, 4:    part = hstg_pkg::ROLE_UP;
                5, 6:    part = hstg_pkg::ROLE_FIFTH;
                default: begin
                    r = $urandom_range(0, 7);
                    part = r[2:0];
                end
            endcase
            r_down = pick_word();
            r_up = pick_word();
            r_fifth = pick_word();
            if ($urandom_range(0, 3) == 0) begin
                floor_hz = pick_word();
            end else begin
                r = $urandom_range(0, 400);
                floor_hz = r[15:0];
            end
        end
        write_reg(hstg_pkg::REG_VOLUME, vol, 16);
        write_reg(hstg_pkg::REG_HARMONY_EN, {15'd0, harmony}, 1);
        write_reg(hstg_pkg::REG_ROLE, {13'd0, part}, 3);
        write_reg(hstg_pkg::REG_RATIO_DOWN, r_down, 16);
        write_reg(hstg_pkg::REG_RATIO_UP, r_up, 16);
        write_reg(hstg_pkg::REG_RATIO_FIFTH, r_fifth, 16);
        write_reg(hstg_pkg::REG_MIN_FREQ, floor_hz, 16);
        write_reg(REG_UNUSED, pick_word(), 16);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rest, slowest tone, quadrant walk, aliasing, top of range
        send(16'd0);
        send(16'd1);
        send(16'd4000);
        send(16'd4000);
        send(16'd4000);
        send(16'd4000);
        send(16'd8000);
        send(16'd16000);
        send(16'd65535);
        send(16'd440);

        wait_samples_out();
        write_reg(hstg_pkg::REG_HARMONY_EN, 16'd1, 1);
        write_reg(hstg_pkg::REG_ROLE, {13'd0, hstg_pkg::ROLE_DOWN}, 3);
        send(16'd60);
        send(16'd100);
        send(16'd0);

        wait_samples_out();
        write_reg(hstg_pkg::REG_ROLE, {13'd0, hstg_pkg::ROLE_UP}, 3);
        send(16'd40000);
        send(16'd300);

        wait_samples_out();
        write_reg(hstg_pkg::REG_ROLE, {13'd0, hstg_pkg::ROLE_FIFTH}, 3);
        send(16'd1000);
        send(16'd65535);

        wait_samples_out();
        write_reg(hstg_pkg::REG_ROLE, 16'd5, 3);
        send(16'd500);

        wait_samples_out();
        write_reg(hstg_pkg::REG_ROLE, {13'd0, hstg_pkg::ROLE_UP}, 3);
        write_reg(hstg_pkg::REG_RATIO_UP, 16'd0, 16);
        send(16'd1000);

        for (int round = 0; round < 12; round++) begin
            wait_samples_out();
            configure(round);
            calm <= ($urandom_range(0, 3) == 0);
            repeat (113) send(pick_tone());
        end

        wait_samples_out();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/hstg_pkg.sv
rtl/core/harmony_sine_tone_generator_unit.sv
tb/sv/sine_sample_checker.sv
tb/sv/testbench.sv
